>>> hw/rtl/chc_pkg.sv
// Package of types, constants and helpers for the clamped histogram counter.
package chc_pkg;

  localparam int MAX_BINS  = 256;
  localparam int IDX_W     = $clog2(MAX_BINS);
  localparam int CFG_W     = 9;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 32;
  localparam int QUEUE_D   = 2;
  localparam int QPTR_W    = $clog2(QUEUE_D);
  localparam int QCNT_W    = $clog2(QUEUE_D + 1);

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] total_count;
    logic [DATA_W-1:0]  max_seen;
    logic [COUNT_W-1:0] overflow_count;
    status_t            status;
  } result_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    op_t               op;
    idx_t              slot;
    logic [DATA_W-1:0] value;
    status_t           status;
  } q_item_t;

  // Saturating increment: stick at all ones.
  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

>>> hw/rtl/chc_front.sv
// Front end: accept items, clamp the bin count in use and classify each item.
module chc_front (
  input  chc_pkg::item_t   item,
  input  logic             start,
  input  chc_pkg::cfg_t    bins_in_use,
  input  logic             full,
  output logic             busy,
  output logic             push,
  output chc_pkg::q_item_t q_item
);

  logic [chc_pkg::DATA_W-1:0] bins_ext;
  logic [chc_pkg::DATA_W-1:0] last_ext;
  logic                       beyond;

  assign bins_ext = chc_pkg::DATA_W'(bins_in_use);

  // Last bin in use; zero bins act as one, too many act as the store size.
  always_comb begin
    if (bins_ext == '0) begin
      last_ext = '0;
    end else if (bins_ext > chc_pkg::DATA_W'(chc_pkg::MAX_BINS)) begin
      last_ext = chc_pkg::DATA_W'(chc_pkg::MAX_BINS - 1);
    end else begin
      last_ext = bins_ext - chc_pkg::DATA_W'(1);
    end
  end

  assign beyond = item.value > last_ext;

  always_comb begin
    q_item.op    = item.op;
    q_item.value = item.value;
    q_item.slot  = item.value[chc_pkg::IDX_W-1:0];
    q_item.status = chc_pkg::ST_OK;
    case (item.op)
      chc_pkg::OP_RECORD: begin
        if (beyond) begin
          q_item.slot   = last_ext[chc_pkg::IDX_W-1:0];
          q_item.status = chc_pkg::ST_CLAMP;
        end
      end
      chc_pkg::OP_READ: begin
        if (beyond) begin
          q_item.status = chc_pkg::ST_RANGE;
        end
      end
      default: begin
        q_item.status = chc_pkg::ST_OK;
      end
    endcase
  end

  assign busy = full;
  assign push = start && !full;

endmodule

>>> hw/rtl/chc_queue.sv
// Short queue of classified items between the front and the back.
module chc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  chc_pkg::q_item_t push_item,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output chc_pkg::q_item_t head
);

  chc_pkg::q_item_t              slots [chc_pkg::QUEUE_D];
  logic [chc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [chc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [chc_pkg::QCNT_W-1:0]    fill;

  assign full      = fill == chc_pkg::QCNT_W'(chc_pkg::QUEUE_D);
  assign not_empty = fill != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == chc_pkg::QPTR_W'(chc_pkg::QUEUE_D - 1)) ? '0
                                                                     : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == chc_pkg::QPTR_W'(chc_pkg::QUEUE_D - 1)) ? '0
                                                                     : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

>>> hw/rtl/chc_back.sv
// Back end: bin store read-modify-write with forwarding, counters and result register.
module chc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  chc_pkg::q_item_t q_item,
  output logic             pop,
  output logic             done,
  output chc_pkg::result_t result
);

  chc_pkg::count_t               store [chc_pkg::MAX_BINS];
  logic [chc_pkg::MAX_BINS-1:0]  written;

  logic                          stage_valid;
  chc_pkg::q_item_t              stage;
  chc_pkg::count_t               rd_data;
  logic                          rd_written;

  logic                          last_wr;
  chc_pkg::idx_t                 last_slot;
  chc_pkg::count_t               last_count;

  chc_pkg::count_t               total;
  chc_pkg::count_t               ovf;
  logic [chc_pkg::DATA_W-1:0]    largest;

  logic                          fwd;
  logic                          wr_en;
  chc_pkg::count_t               cur;
  chc_pkg::count_t               bumped;
  chc_pkg::count_t               total_next;
  chc_pkg::count_t               ovf_next;
  logic [chc_pkg::DATA_W-1:0]    largest_next;
  chc_pkg::result_t              result_next;

  // The back never stalls: take the head item whenever there is one.
  assign pop = q_valid;

  // Read the store and its written flag for the head item; write back bumped counts.
  always_ff @(posedge clk) begin
    if (q_valid) begin
      rd_data <= store[q_item.slot];
      stage   <= q_item;
    end
    if (wr_en) begin
      store[stage.slot] <= bumped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (q_valid) begin
        rd_written <= written[q_item.slot];
      end
      if (wr_en) begin
        written[stage.slot] <= 1'b1;
      end
    end
  end

  // The write of the previous item lands at the same edge as this read: forward it.
  assign fwd    = last_wr && (last_slot == stage.slot);
  assign cur    = fwd ? last_count : (rd_written ? rd_data : '0);
  assign bumped = chc_pkg::sat_inc(cur);
  assign wr_en  = stage_valid && (stage.op == chc_pkg::OP_RECORD);

  always_comb begin
    total_next   = total;
    ovf_next     = ovf;
    largest_next = largest;
    if (wr_en) begin
      total_next = chc_pkg::sat_inc(total);
      if (stage.status == chc_pkg::ST_CLAMP) begin
        ovf_next = chc_pkg::sat_inc(ovf);
      end
      if (stage.value > largest) begin
        largest_next = stage.value;
      end
    end
  end

  always_comb begin
    result_next.total_count    = total_next;
    result_next.max_seen       = largest_next;
    result_next.overflow_count = ovf_next;
    result_next.status         = stage.status;
    case (stage.op)
      chc_pkg::OP_RECORD: result_next.bin_count = bumped;
      chc_pkg::OP_READ:   result_next.bin_count =
                            (stage.status == chc_pkg::ST_RANGE) ? '0 : cur;
      default:            result_next.bin_count = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      last_wr     <= 1'b0;
      done        <= 1'b0;
      total       <= '0;
      ovf         <= '0;
      largest     <= '0;
    end else begin
      stage_valid <= q_valid;
      last_wr     <= wr_en;
      done        <= stage_valid;
      total       <= total_next;
      ovf         <= ovf_next;
      largest     <= largest_next;
    end
  end

  always_ff @(posedge clk) begin
    last_slot  <= stage.slot;
    last_count <= bumped;
    if (stage_valid) begin
      result <= result_next;
    end
  end

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == chc_pkg::ST_RANGE) |-> (result.bin_count == '0))
    else $error("out of range read returned a nonzero count");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst)) |-> (total >= $past(total)))
    else $error("total count went down");

  a_ovf_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ovf != $past(ovf)) |->
      $past(wr_en && stage.status == chc_pkg::ST_CLAMP))
    else $error("overflow count moved without a clamped sample");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && done) |-> $past(stage_valid))
    else $error("result strobe without an item in the stage");

endmodule

>>> hw/rtl/clamped_histogram_counter.sv
// Top level of the clamped histogram counter: front, queue, back and the bin-count register.
//
// Histogram engine with an overflow bin. Raise start with an item (record a
// sample, or read one bin) in any cycle in which busy is low; the item is
// taken at that edge. Each item gives exactly one result, shown on result for
// one cycle with done high, taken from the result register, and results
// come out in item order. The block accepts one item every cycle: the front
// classifies the item into a queue of two, and the back reads the bin store
// (a 256-entry memory with registered read), bumps the count and writes it
// back in the next cycle, forwarding the new count when the next item hits the
// same bin, so the store's single read and write ports set the rate of one
// item per cycle. The receiver cannot hold results off, so busy only rises if
// the queue ever fills. Counters saturate at all ones. A sample beyond the last
// bin in use is clamped into it with status 1; a read beyond it returns count
// zero with status 2. Reset clears the store at once through a written flag per
// bin, so no clearing pass is needed. Write bins_in_use on the cfg channel
// (always ready) only while no result is pending; 0 acts as 1 and values above
// 256 act as 256. Changing it does not clear any bin.
module clamped_histogram_counter (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  chc_pkg::item_t    item,
  output logic              done,
  output chc_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  chc_pkg::cfg_t     cfg_data
);

  chc_pkg::cfg_t     bins_in_use;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  chc_pkg::q_item_t  q_in;
  chc_pkg::q_item_t  q_head;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= chc_pkg::cfg_t'(chc_pkg::MAX_BINS);
    end else if (cfg_valid && cfg_ready) begin
      bins_in_use <= cfg_data;
    end
  end

  // Classify each item against the bins in use.
  chc_front u_front (
    .item        (item),
    .start       (start),
    .bins_in_use (bins_in_use),
    .full        (q_full),
    .busy        (busy),
    .push        (q_push),
    .q_item      (q_in)
  );

  // Decouple acceptance from the store update.
  chc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Update the store and counters, and drive the result.
  chc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_item  (q_head),
    .pop     (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

>>> tb/clamped_histogram_counter_test.sv
// Self-checking testbench for the clamped histogram counter: directed table, then random phases.
`timescale 1ns / 1ps

module clamped_histogram_counter_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 650;
  localparam int SETTLE_CYCLES = 8;

  // Kind of row in the directed table: an item, or a write of bins_in_use.
  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    chc_pkg::op_t      op;
    logic [31:0]       value;   // sample, bin index, or bins_in_use for ROW_CFG
    logic              pinned;  // want holds a result read straight off the spec
    chc_pkg::result_t  want;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  chc_pkg::item_t    item;
  logic              done;
  chc_pkg::result_t  result;
  logic              cfg_valid;
  logic              cfg_ready;
  chc_pkg::cfg_t     cfg_data;

  // Pinned expectation travelling alongside the item being offered.
  logic              pinned_valid;
  chc_pkg::result_t  pinned_result;

  // Shadow histogram: own copy of the bins, the counters and the register.
  chc_pkg::count_t   bin_counts [chc_pkg::MAX_BINS];
  chc_pkg::count_t   sample_count;
  logic [31:0]       peak_value;
  chc_pkg::count_t   clamp_count;
  chc_pkg::cfg_t     bins_setting;

  chc_pkg::result_t  pending_results [$];
  logic [31:0]       last_value;
  int                mismatches;
  int                cycle_count;

  // Directed part. Rows up to the first register write start from reset, and most
  // of their results are typed in; elsewhere the shadow histogram decides.
  dir_row_t dir_rows [29] = '{
    // Empty histogram: first and last bin read zero, reads past the end flag range.
    '{ROW_ITEM, chc_pkg::OP_READ, 32'd0, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, chc_pkg::ST_OK}},
    '{ROW_ITEM, chc_pkg::OP_READ, 32'd255, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, chc_pkg::ST_OK}},
    '{ROW_ITEM, chc_pkg::OP_READ, 32'd256, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, chc_pkg::ST_RANGE}},
    '{ROW_ITEM, chc_pkg::OP_READ, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, chc_pkg::ST_RANGE}},
    // First and last bin, then clamping into the last bin.
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd0, 1'b1,
      '{32'd1, 32'd1, 32'd0, 32'd0, chc_pkg::ST_OK}},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd255, 1'b1,
      '{32'd1, 32'd2, 32'd255, 32'd0, chc_pkg::ST_OK}},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd256, 1'b1,
      '{32'd2, 32'd3, 32'd256, 32'd1, chc_pkg::ST_CLAMP}},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'hFFFF_FFFF, 1'b1,
      '{32'd3, 32'd4, 32'hFFFF_FFFF, 32'd2, chc_pkg::ST_CLAMP}},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd0, 1'b1,
      '{32'd2, 32'd5, 32'hFFFF_FFFF, 32'd2, chc_pkg::ST_OK}},
    '{ROW_ITEM, chc_pkg::OP_READ, 32'd255, 1'b1,
      '{32'd3, 32'd5, 32'hFFFF_FFFF, 32'd2, chc_pkg::ST_OK}},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'h0000_0055, 1'b0, '0},
    // Zero bins in use behaves as a single bin.
    '{ROW_CFG,  chc_pkg::OP_READ,   32'd0,         1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd0,         1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd1,         1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd0,         1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd1,         1'b0, '0},
    // Shrink: bins beyond the end keep their counts but cannot be read.
    '{ROW_CFG,  chc_pkg::OP_READ,   32'd4,         1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd255,       1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd255,       1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd3,         1'b0, '0},
    // Above the store size behaves as the full store; old counts reappear.
    '{ROW_CFG,  chc_pkg::OP_READ,   32'd511,       1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd255,       1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_RECORD, 32'd255,       1'b0, '0},
    '{ROW_CFG,  chc_pkg::OP_READ,   32'd1,         1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd0,         1'b0, '0},
    '{ROW_CFG,  chc_pkg::OP_READ,   32'd256,       1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd255,       1'b0, '0},
    '{ROW_ITEM, chc_pkg::OP_READ,   32'd3,         1'b0, '0}
  };

  // Settings visited first in the random part, then mixed in at random.
  chc_pkg::cfg_t edge_settings [7] = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};

  clamped_histogram_counter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bins in effect: zero acts as one, anything past the store acts as the store.
  function automatic int active_bins();
    if (bins_setting == '0) return 1;
    if (int'(bins_setting) > chc_pkg::MAX_BINS) return chc_pkg::MAX_BINS;
    return int'(bins_setting);
  endfunction

  // Stick at all ones rather than wrap.
  function automatic chc_pkg::count_t bump(chc_pkg::count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Apply one accepted item to the shadow histogram and return its result.
  function automatic chc_pkg::result_t histogram_step(chc_pkg::item_t it);
    chc_pkg::result_t  r;
    logic [31:0]       last_bin;
    logic [31:0]       slot;
    last_bin = 32'(active_bins() - 1);
    r = '0;
    r.status = chc_pkg::ST_OK;
    if (it.op == chc_pkg::OP_RECORD) begin
      slot = it.value;
      if (it.value > peak_value) peak_value = it.value;
      if (it.value > last_bin) begin
        slot = last_bin;
        r.status = chc_pkg::ST_CLAMP;
        clamp_count = bump(clamp_count);
      end
      sample_count = bump(sample_count);
      bin_counts[slot[chc_pkg::IDX_W-1:0]] = bump(bin_counts[slot[chc_pkg::IDX_W-1:0]]);
      r.bin_count = bin_counts[slot[chc_pkg::IDX_W-1:0]];
    end else if (it.value > last_bin) begin
      r.status = chc_pkg::ST_RANGE;
    end else begin
      r.bin_count = bin_counts[it.value[chc_pkg::IDX_W-1:0]];
    end
    r.total_count = sample_count;
    r.max_seen = peak_value;
    r.overflow_count = clamp_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sample everything at the rising edge: track register writes, predict each
  // accepted item, and hold every strobed result against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    chc_pkg::result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) bins_setting = cfg_data;
      if (start && !busy) begin
        want = histogram_step(item);
        // A pinned row still advances the shadow state, but its typed result wins.
        if (pinned_valid) want = pinned_result;
        pending_results.push_back(want);
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with nothing expected: %p", result);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("bin_count", want.bin_count, result.bin_count);
          check_field("total_count", want.total_count, result.total_count);
          check_field("max_seen", want.max_seen, result.max_seen);
          check_field("overflow_count", want.overflow_count, result.overflow_count);
          check_field("status", 32'(want.status), 32'(result.status));
        end
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle for gap cycles, then offer the item and hold it until taken. Return on
  // the falling edge after acceptance with start still high, so a back-to-back
  // item costs no bubble.
  task automatic send_item(chc_pkg::op_t op, logic [31:0] value, logic pin,
                           chc_pkg::result_t pin_res, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= '{op: op, value: value};
    pinned_valid <= pin;
    pinned_result <= pin_res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_bins(chc_pkg::cfg_t setting);
    cfg_valid <= 1'b1;
    cfg_data <= setting;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly no idling, some short gaps, a few long ones; mode 0 never idles.
  function automatic int pick_gap(int mode);
    int unsigned roll;
    if (mode == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias towards the edges of the active range and towards hitting the same
  // bin twice in a row, which exercises the store's forwarding path.
  function automatic chc_pkg::item_t random_item();
    chc_pkg::item_t  it;
    logic [31:0]     top;
    int unsigned     pick;
    top = 32'(active_bins() - 1);
    pick = $urandom_range(0, 99);
    it.op = (pick < 66) ? chc_pkg::OP_RECORD : chc_pkg::OP_READ;
    if (pick < 35) it.value = $urandom_range(0, top);
    else if (pick < 45) it.value = last_value;
    else if (pick < 55) it.value = top + $urandom_range(1, 4);
    else if (pick < 62) it.value = $urandom();
    else if (pick < 66) it.value = pick[0] ? '1 : '0;
    else if (pick < 88) it.value = $urandom_range(0, top);
    else if (pick < 95) it.value = top + $urandom_range(1, 4);
    else it.value = $urandom();
    last_value = it.value;
    return it;
  endfunction

  initial begin
    chc_pkg::item_t  it;
    chc_pkg::cfg_t   setting;
    int              sent;
    int              phase;
    int              phase_len;
    int              gap_mode;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    pinned_valid = 1'b0;
    pinned_result = '0;
    mismatches = 0;
    cycle_count = 0;
    last_value = '0;
    // Shadow state as it stands after reset.
    foreach (bin_counts[i]) bin_counts[i] = '0;
    sample_count = '0;
    peak_value = '0;
    clamp_count = '0;
    bins_setting = chc_pkg::cfg_t'(chc_pkg::MAX_BINS);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table; register writes only once the block is idle.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_bins(chc_pkg::cfg_t'(dir_rows[i].value));
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].pinned, dir_rows[i].want, 0);
      end
    end

    // Random phases: new setting at each boundary, extremes first, then a mix
    // of extremes, small histograms (dense collisions) and anything at all.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (phase < 7) setting = edge_settings[phase];
      else if ($urandom_range(0, 2) == 0) setting = edge_settings[$urandom_range(0, 6)];
      else if ($urandom_range(0, 1) == 0) setting = chc_pkg::cfg_t'($urandom_range(1, 16));
      else setting = chc_pkg::cfg_t'($urandom_range(0, 511));
      write_bins(setting);
      gap_mode = $urandom_range(0, 3);
      phase_len = $urandom_range(30, 60);
      repeat (phase_len) begin
        it = random_item();
        send_item(it.op, it.value, 1'b0, '0, pick_gap(gap_mode));
        sent++;
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
